@@ sv/gja_pkg.sv @@
package gja_pkg;

	localparam int SRV_W = 4;
	localparam int VAL_W = 16;
	localparam int TOT_W = 32;
	localparam int CNT_W = 16;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_JOB  = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [SRV_W-1:0] server;
		logic [VAL_W-1:0] time_value;
		logic [VAL_W-1:0] cost_value;
		logic             last_server;
	} item_t;

	typedef struct packed {
		logic [SRV_W-1:0] assigned_server;
		logic             went_local;
		logic [VAL_W-1:0] cost_charged;
		logic [VAL_W-1:0] remaining_capacity;
		logic [TOT_W-1:0] total_cost;
	} result_t;

	typedef logic [VAL_W-1:0] cfg_word_t;

	// Capacity with a sticky flag for a subtraction that went below zero.
	// Such a capacity stays huge: every later job fits until it is reloaded.
	typedef struct packed {
		logic             neg;
		logic [VAL_W-1:0] val;
	} cap_t;

	typedef struct packed {
		logic             found;
		logic [SRV_W-1:0] srv;
		logic [VAL_W-1:0] tm;
		logic [VAL_W-1:0] cost;
		cap_t             cap;
	} choice_t;

	typedef struct packed {
		logic             load;
		logic [SRV_W-1:0] load_srv;
		logic [VAL_W-1:0] load_cap;
		logic             take;
		logic [SRV_W-1:0] take_srv;
		cap_t             take_cap;
		logic [VAL_W-1:0] take_cost;
	} tbl_upd_t;

	function automatic logic [TOT_W-1:0] sat_add32(input logic [TOT_W-1:0] a,
			input logic [TOT_W-1:0] b);
		logic [TOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOT_W] ? '1 : s[TOT_W-1:0];
	endfunction

	function automatic cap_t cap_sub(input cap_t c, input logic [VAL_W-1:0] t);
		logic [VAL_W:0] d;
		cap_t r;
		d = {1'b0, c.val} - {1'b0, t};
		r.neg = c.neg | d[VAL_W];
		r.val = d[VAL_W-1:0];
		return r;
	endfunction

endpackage

@@ sv/gja_if.sv @@
interface gja_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/gja_srv_table.sv @@
module gja_srv_table #(
	parameter int SERVERS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [gja_pkg::SRV_W-1:0] rd_srv,
	output logic                     rd_in_range,
	output gja_pkg::cap_t            rd_cap,
	input  gja_pkg::tbl_upd_t        upd
);
	import gja_pkg::*;

	localparam int DEPTH = (SERVERS < (1 << SRV_W)) ? SERVERS : (1 << SRV_W);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cap_t             cap_q  [DEPTH];
	logic [CNT_W-1:0] jobs_q [DEPTH];
	logic [TOT_W-1:0] cost_q [DEPTH];

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] tk_idx;
	logic [IDX_W-1:0] ld_idx;

	assign rd_in_range = 32'(rd_srv) < SERVERS;
	assign rd_idx = rd_srv[IDX_W-1:0];
	assign tk_idx = upd.take_srv[IDX_W-1:0];
	assign ld_idx = upd.load_srv[IDX_W-1:0];
	assign rd_cap = rd_in_range ? cap_q[rd_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				cap_q[i]  <= '0;
				jobs_q[i] <= '0;
				cost_q[i] <= '0;
			end
		end else if (upd.load && (32'(upd.load_srv) < SERVERS)) begin
			cap_q[ld_idx]  <= '{neg: 1'b0, val: upd.load_cap};
			jobs_q[ld_idx] <= '0;
			cost_q[ld_idx] <= '0;
		end else if (upd.take && (32'(upd.take_srv) < SERVERS)) begin
			cap_q[tk_idx] <= upd.take_cap;
			if (jobs_q[tk_idx] != '1) begin
				jobs_q[tk_idx] <= jobs_q[tk_idx] + CNT_W'(1);
			end
			cost_q[tk_idx] <= sat_add32(cost_q[tk_idx], TOT_W'(upd.take_cost));
		end
	end

endmodule

@@ sv/gja_tracker.sv @@
module gja_tracker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_fire,
	input  gja_pkg::item_t            item,
	input  logic                      fits,
	input  gja_pkg::cap_t             cap_rd,
	input  logic                      load_fire,
	input  logic [gja_pkg::SRV_W-1:0] load_srv,
	input  logic [gja_pkg::VAL_W-1:0] load_cap,
	output gja_pkg::choice_t          choice
);
	import gja_pkg::*;

	logic             job_open_q;
	logic [VAL_W-1:0] best_time_q;
	logic [SRV_W-1:0] best_srv_q;
	logic [VAL_W-1:0] best_cost_q;
	logic             best_fits_q;
	cap_t             best_cap_q;
	logic             fit_found_q;
	logic [SRV_W-1:0] fit_srv_q;
	logic [VAL_W-1:0] fit_time_q;
	logic [VAL_W-1:0] fit_cost_q;
	cap_t             fit_cap_q;

	logic             new_best;
	logic             new_fit;
	logic [VAL_W-1:0] nb_time;
	logic [SRV_W-1:0] nb_srv;
	logic [VAL_W-1:0] nb_cost;
	logic             nb_fits;
	cap_t             nb_cap;
	logic             nf_found;
	logic [SRV_W-1:0] nf_srv;
	logic [VAL_W-1:0] nf_time;
	logic [VAL_W-1:0] nf_cost;
	cap_t             nf_cap;

	// The first item of a job always takes the lowest-time slot.
	assign new_best = !job_open_q || (item.time_value < best_time_q);
	assign new_fit  = fits && !fit_found_q;

	assign nb_time  = new_best ? item.time_value : best_time_q;
	assign nb_srv   = new_best ? item.server : best_srv_q;
	assign nb_cost  = new_best ? item.cost_value : best_cost_q;
	assign nb_fits  = new_best ? fits : best_fits_q;
	assign nb_cap   = new_best ? cap_rd : best_cap_q;
	assign nf_found = fit_found_q || fits;
	assign nf_srv   = new_fit ? item.server : fit_srv_q;
	assign nf_time  = new_fit ? item.time_value : fit_time_q;
	assign nf_cost  = new_fit ? item.cost_value : fit_cost_q;
	assign nf_cap   = new_fit ? cap_rd : fit_cap_q;

	always_comb begin
		choice.found = nb_fits || nf_found;
		if (nb_fits) begin
			choice.srv  = nb_srv;
			choice.tm   = nb_time;
			choice.cost = nb_cost;
			choice.cap  = nb_cap;
		end else begin
			choice.srv  = nf_srv;
			choice.tm   = nf_time;
			choice.cost = nf_cost;
			choice.cap  = nf_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_open_q  <= 1'b0;
			best_time_q <= '1;
			best_srv_q  <= '0;
			best_cost_q <= '0;
			best_fits_q <= 1'b0;
			best_cap_q  <= '0;
			fit_found_q <= 1'b0;
			fit_srv_q   <= '0;
			fit_time_q  <= '0;
			fit_cost_q  <= '0;
			fit_cap_q   <= '0;
		end else if (job_fire) begin
			if (item.last_server) begin
				job_open_q  <= 1'b0;
				best_time_q <= '1;
				best_srv_q  <= '0;
				best_cost_q <= '0;
				best_fits_q <= 1'b0;
				fit_found_q <= 1'b0;
				fit_srv_q   <= '0;
				fit_time_q  <= '0;
				fit_cost_q  <= '0;
			end else begin
				job_open_q  <= 1'b1;
				best_time_q <= nb_time;
				best_srv_q  <= nb_srv;
				best_cost_q <= nb_cost;
				best_fits_q <= nb_fits;
				best_cap_q  <= nb_cap;
				fit_found_q <= nf_found;
				fit_srv_q   <= nf_srv;
				fit_time_q  <= nf_time;
				fit_cost_q  <= nf_cost;
				fit_cap_q   <= nf_cap;
			end
		end else if (load_fire) begin
			// A reload in the middle of a job changes what the tracked servers will give back.
			if (load_srv == best_srv_q) begin
				best_cap_q <= '{neg: 1'b0, val: load_cap};
			end
			if (load_srv == fit_srv_q) begin
				fit_cap_q <= '{neg: 1'b0, val: load_cap};
			end
		end
	end

endmodule

@@ sv/greedy_job_to_server_assigner.sv @@
// Channel   Dir  Payload                                          Transaction
// items     in   kind, server, time_value, cost_value, last_server  valid && ready
// results   out  assigned_server, went_local, cost_charged,
//                remaining_capacity, total_cost                   valid && ready
// cfg       in   fixed_cost                                       valid && ready
//
// One item enters per cycle while no stalled result holds it back. In the input register
// the capacity table read, the tracker update and the final choice are done; a result is
// then written from there to the output register.
// Reset clears the capacity table, the per-server totals, the trackers and fixed_cost.
// A stalled result holds the output register; items that give no result keep flowing, and
// the next item that closes a job waits in the input register until the result is taken.
module greedy_job_to_server_assigner #(
	parameter int SERVERS   = 16,
	parameter int TIME_BITS = 16,
	parameter int COST_BITS = 16
) (
	input logic    clk,
	input logic    arst_n,
	gja_if.sink    items,
	gja_if.source  results,
	gja_if.sink    cfg
);
	import gja_pkg::*;

	localparam logic [VAL_W-1:0] TIME_MASK =
		(TIME_BITS >= VAL_W) ? '1 : VAL_W'((33'd1 << TIME_BITS) - 33'd1);
	localparam logic [VAL_W-1:0] COST_MASK =
		(COST_BITS >= VAL_W) ? '1 : VAL_W'((33'd1 << COST_BITS) - 33'd1);

	logic [VAL_W-1:0] fixed_cost_q;
	logic             valid_s1;
	item_t            item_s1;
	logic             out_valid_q;
	result_t          result_q;
	logic [TOT_W-1:0] solution_cost_q;

	item_t            item_m;
	logic             is_job;
	logic             produce;
	logic             adv_s1;
	logic             job_fire;
	logic             load_fire;
	logic             take;
	logic             in_range;
	logic             fits;
	cap_t             cap_rd;
	cap_t             new_cap;
	choice_t          choice;
	tbl_upd_t         upd;
	logic [VAL_W-1:0] charged;
	logic [TOT_W-1:0] next_total;

	always_comb begin
		item_m            = item_s1;
		item_m.time_value = item_s1.time_value & TIME_MASK;
		item_m.cost_value = item_s1.cost_value & COST_MASK;
	end

	assign is_job    = item_s1.kind == KIND_JOB;
	assign produce   = valid_s1 && is_job && item_s1.last_server;
	assign adv_s1    = valid_s1 && (!produce || !out_valid_q || results.ready);
	assign job_fire  = adv_s1 && is_job;
	assign load_fire = adv_s1 && (item_s1.kind == KIND_LOAD) && in_range;
	assign take      = job_fire && item_s1.last_server && choice.found;

	assign fits = in_range && (cap_rd.neg || (item_m.time_value <= cap_rd.val));

	assign new_cap    = cap_sub(choice.cap, choice.tm);
	assign charged    = choice.found ? choice.cost : fixed_cost_q;
	assign next_total = sat_add32(solution_cost_q, TOT_W'(charged));

	assign upd.load      = load_fire;
	assign upd.load_srv  = item_m.server;
	assign upd.load_cap  = item_m.time_value;
	assign upd.take      = take;
	assign upd.take_srv  = choice.srv;
	assign upd.take_cap  = new_cap;
	assign upd.take_cost = choice.cost;

	gja_srv_table #(
		.SERVERS(SERVERS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_srv     (item_m.server),
		.rd_in_range(in_range),
		.rd_cap     (cap_rd),
		.upd        (upd)
	);

	gja_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_fire (job_fire),
		.item     (item_m),
		.fits     (fits),
		.cap_rd   (cap_rd),
		.load_fire(load_fire),
		.load_srv (item_m.server),
		.load_cap (item_m.time_value),
		.choice   (choice)
	);

	assign items.ready     = !valid_s1 || adv_s1;
	assign cfg.ready       = 1'b1;
	assign results.valid   = out_valid_q;
	assign results.payload = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_cost_q <= '0;
		end else if (cfg.valid) begin
			fixed_cost_q <= cfg.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			solution_cost_q <= '0;
		end else if (produce && adv_s1) begin
			out_valid_q     <= 1'b1;
			solution_cost_q <= next_total;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce && adv_s1) begin
			result_q.assigned_server    <= choice.found ? choice.srv : '0;
			result_q.went_local         <= !choice.found;
			result_q.cost_charged       <= charged;
			result_q.remaining_capacity <= choice.found ? new_cap.val : '0;
			result_q.total_cost         <= next_total;
		end
	end

	a_local_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.went_local |->
			result_q.assigned_server == '0 && result_q.remaining_capacity == '0)
		else $error("local result carries a server or a capacity");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		produce && adv_s1 |=> solution_cost_q >= $past(solution_cost_q))
		else $error("solution cost went down");

	a_take_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> 32'(choice.srv) < SERVERS)
		else $error("job assigned to a server that does not exist");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("stalled item lost from the input register");

endmodule
